>>> sv/length_framed_packet_receiver_unit_assert.svh
// Assertion macros shared by the receiver RTL.
`ifndef LENGTH_FRAMED_PACKET_RECEIVER_UNIT_ASSERT_SVH
`define LENGTH_FRAMED_PACKET_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LFPR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LFPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/lfpr_pkg.sv
package lfpr_pkg;

	// Frame layout: start marker, type, four timestamp bytes, length byte.
	localparam logic [7:0] HEADER_BYTES  = 8'd7;
	localparam logic [7:0] POS_HUNT      = 8'd0;
	localparam logic [7:0] POS_TYPE      = 8'd1;
	localparam logic [7:0] POS_LENGTH    = 8'd6;
	// Payload length cap that keeps every frame position below 255 in 8 bits.
	localparam logic [7:0] LIMIT_CEILING = 8'd247;

	localparam logic [7:0] START_MARKER_RESET = 8'hAA;
	localparam logic [7:0] MAX_PAYLOAD_RESET  = 8'd200;

	// Configuration register indexes.
	localparam logic REG_START_MARKER = 1'b0;
	localparam logic REG_MAX_PAYLOAD  = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
	localparam logic [1:0] KIND_GOOD      = 2'd1;
	localparam logic [1:0] KIND_BAD_SUM   = 2'd2;
	localparam logic [1:0] KIND_TOO_LONG  = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [7:0]  byte_index;
		logic [7:0]  frame_type;
		logic [31:0] frame_timestamp;
		logic [7:0]  frame_length;
		logic        frame_end;
	} result_t;

	typedef struct packed {
		logic load;     // an item was accepted this cycle
		logic produce;  // that item yields a result
	} step_ctl_t;

endpackage

>>> sv/lfpr_tracker.sv
module lfpr_tracker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          start_marker,
	input  logic [7:0]          max_payload,
	output lfpr_pkg::step_ctl_t ctl,
	output lfpr_pkg::result_t   result
);

	logic [7:0]  pos_q;
	logic [7:0]  xor_q;
	logic [7:0]  type_q;
	logic [31:0] stamp_q;
	logic [7:0]  length_q;

	logic [7:0]  pos_d;
	logic [7:0]  xor_d;
	logic [7:0]  type_d;
	logic [31:0] stamp_d;
	logic [7:0]  length_d;
	logic [7:0]  limit;
	logic [7:0]  rel;
	logic        produce;
	logic [1:0]  kind;
	logic        is_payload;

	assign limit = (max_payload > lfpr_pkg::LIMIT_CEILING) ? lfpr_pkg::LIMIT_CEILING
		: max_payload;
	assign rel = pos_q - lfpr_pkg::HEADER_BYTES;

	always_comb begin
		pos_d      = pos_q;
		xor_d      = xor_q;
		type_d     = type_q;
		stamp_d    = stamp_q;
		length_d   = length_q;
		produce    = 1'b0;
		kind       = lfpr_pkg::KIND_PAYLOAD;
		is_payload = 1'b0;
		priority if (pos_q == lfpr_pkg::POS_HUNT) begin
			if (rx_byte == start_marker) begin
				xor_d = rx_byte;
				pos_d = lfpr_pkg::POS_TYPE;
			end
		end else if (pos_q == lfpr_pkg::POS_TYPE) begin
			type_d = rx_byte;
			xor_d  = xor_q ^ rx_byte;
			pos_d  = pos_q + 8'd1;
		end else if (pos_q < lfpr_pkg::POS_LENGTH) begin
			stamp_d = {stamp_q[23:0], rx_byte};
			xor_d   = xor_q ^ rx_byte;
			pos_d   = pos_q + 8'd1;
		end else if (pos_q == lfpr_pkg::POS_LENGTH) begin
			length_d = rx_byte;
			xor_d    = xor_q ^ rx_byte;
			if (rx_byte > limit) begin
				// Oversized frame: report it and go straight back to hunting.
				pos_d   = lfpr_pkg::POS_HUNT;
				produce = 1'b1;
				kind    = lfpr_pkg::KIND_TOO_LONG;
			end else begin
				pos_d = lfpr_pkg::HEADER_BYTES;
			end
		end else if (rel < length_q) begin
			xor_d      = xor_q ^ rx_byte;
			pos_d      = pos_q + 8'd1;
			produce    = 1'b1;
			is_payload = 1'b1;
		end else begin
			// Checksum byte closes the frame.
			pos_d   = lfpr_pkg::POS_HUNT;
			produce = 1'b1;
			kind    = (rx_byte == xor_q) ? lfpr_pkg::KIND_GOOD : lfpr_pkg::KIND_BAD_SUM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= lfpr_pkg::POS_HUNT;
			xor_q    <= '0;
			type_q   <= '0;
			stamp_q  <= '0;
			length_q <= '0;
		end else if (load) begin
			pos_q    <= pos_d;
			xor_q    <= xor_d;
			type_q   <= type_d;
			stamp_q  <= stamp_d;
			length_q <= length_d;
		end
	end

	assign ctl.load    = load;
	assign ctl.produce = produce;

	assign result.kind            = kind;
	assign result.payload_byte    = is_payload ? rx_byte : 8'd0;
	assign result.byte_index      = is_payload ? rel : 8'd0;
	assign result.frame_type      = type_d;
	assign result.frame_timestamp = stamp_d;
	assign result.frame_length    = length_d;
	assign result.frame_end       = ~is_payload;

endmodule

>>> sv/lfpr_out_stage.sv
module lfpr_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  lfpr_pkg::step_ctl_t ctl,
	input  lfpr_pkg::result_t   result,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                room,
	output lfpr_pkg::result_t   held
);

	logic              valid_q;
	lfpr_pkg::result_t data_q;

	// A new item may enter when the register is empty or drains this cycle.
	assign room = ~valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= ctl.produce;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && ctl.produce) begin
			data_q <= result;
		end
	end

	assign out_valid = valid_q;
	assign held      = data_q;

endmodule

>>> sv/length_framed_packet_receiver_unit.sv
// Any result item of an accepted byte is registered and offered on out_valid in the next cycle.
// Throughput: one byte per cycle; the single output register drains and refills in the
// same cycle, so in_ready only drops while a result waits and out_ready is low.
// Reset (arst_n low, asynchronous): hunting for the start marker, checksum and header
// holds cleared, no result pending, start_marker = 0xAA and max_payload = 200.
module length_framed_packet_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [7:0]  wr_data,
	// Input channel: one received byte per item.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// Output channel: payload bytes and frame status items.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  byte_index,
	output logic [7:0]  frame_type,
	output logic [31:0] frame_timestamp,
	output logic [7:0]  frame_length,
	output logic        frame_end
);

	`include "length_framed_packet_receiver_unit_assert.svh"

	// Configuration registers. The user must see that they are only written while the block
	// is idle, so the tracker may read them directly; the block itself does not enforce it.
	logic [7:0] start_marker_q;
	logic [7:0] max_payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= lfpr_pkg::START_MARKER_RESET;
			max_payload_q  <= lfpr_pkg::MAX_PAYLOAD_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				lfpr_pkg::REG_START_MARKER: start_marker_q <= wr_data;
				lfpr_pkg::REG_MAX_PAYLOAD:  max_payload_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// An item is taken whenever the output register has room for its result.
	logic                room;
	logic                load;
	lfpr_pkg::step_ctl_t ctl;
	lfpr_pkg::result_t   result;
	lfpr_pkg::result_t   held;

	assign in_ready = room;
	assign load     = in_valid & room;

	// The tracker holds the frame position, running XOR and header fields,
	// and works out the result of the accepted byte in the same cycle.
	lfpr_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.rx_byte      (rx_byte),
		.start_marker (start_marker_q),
		.max_payload  (max_payload_q),
		.ctl          (ctl),
		.result       (result)
	);

	// The result register separates the input side from the output side.
	lfpr_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.result    (result),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.room      (room),
		.held      (held)
	);

	assign kind            = held.kind;
	assign payload_byte    = held.payload_byte;
	assign byte_index      = held.byte_index;
	assign frame_type      = held.frame_type;
	assign frame_timestamp = held.frame_timestamp;
	assign frame_length    = held.frame_length;
	assign frame_end       = held.frame_end;

	// Status items, and only status items, close a frame.
	`LFPR_ASSERT_NOW(a_end_matches_kind, out_valid,
		frame_end == (kind != lfpr_pkg::KIND_PAYLOAD), "frame_end disagrees with kind")
	// A payload byte always lies inside the announced length.
	`LFPR_ASSERT_NOW(a_index_in_range, out_valid && kind == lfpr_pkg::KIND_PAYLOAD,
		byte_index < frame_length, "payload index beyond frame length")
	// An empty output register never holds off the input.
	`LFPR_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled while empty")
	// A stalled result is never overwritten.
	`LFPR_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(kind),
		"pending result lost")

endmodule
